### hw/rtl/stt_pkg.sv
package stt_pkg;

    localparam int CP_W        = 21;
    localparam int EV_W        = 4;
    localparam int IDX_W       = 7;
    localparam int KW_POS_W    = 3;
    localparam int KW_LEN      = 8;
    localparam int TEXT_CAPACITY_DEF = 64;
    localparam int MAX_MEMBERS_DEF   = 128;

    localparam logic [CP_W-1:0] CH_S     = CP_W'(8'h73);
    localparam logic [CP_W-1:0] CH_RBRACE = CP_W'(8'h7D);
    localparam logic [CP_W-1:0] CH_UNDER = CP_W'(8'h5F);
    localparam logic [CP_W-1:0] CH_SPACE = CP_W'(8'h20);
    localparam logic [CP_W-1:0] CH_TAB   = CP_W'(8'h09);

    typedef enum logic [3:0] {
        MODE_SEEK_S,
        MODE_KEYWORD,
        MODE_BLANKS,
        MODE_NAME,
        MODE_SEEK_TYPE,
        MODE_TYPE,
        MODE_SEEK_IDENT,
        MODE_IDENT,
        MODE_SEEK_END,
        MODE_HALTED
    } t_mode;

    typedef enum logic [EV_W-1:0] {
        EV_NONE,
        EV_NAME_CHAR,
        EV_NAME_END,
        EV_TYPE_CHAR,
        EV_TYPE_END,
        EV_IDENT_CHAR,
        EV_IDENT_END,
        EV_STRUCT_END,
        EV_FINISHED,
        EV_BAD_KEYWORD,
        EV_TOO_LONG,
        EV_BAD_IDENT,
        EV_TOO_MANY,
        EV_UNEXPECTED_END
    } t_event;

    typedef struct packed {
        logic letter;
        logic word;
        logic blank;
        logic is_s;
        logic rbrace;
        logic kw_match;
    } t_char_class;

    function automatic logic [7:0] kw_tail(input logic [KW_POS_W-1:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h74;
            3'd1:    ch = 8'h72;
            3'd2:    ch = 8'h75;
            3'd3:    ch = 8'h63;
            3'd4:    ch = 8'h74;
            3'd5:    ch = 8'h75;
            3'd6:    ch = 8'h72;
            3'd7:    ch = 8'h65;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### hw/rtl/stt_if.sv
interface stt_in_if import stt_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            end_of_input;

    modport source (output valid, output code_point, output end_of_input, input ready);
    modport sink   (input valid, input code_point, input end_of_input, output ready);
endinterface

interface stt_out_if import stt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [EV_W-1:0]  event_res;
    logic [CP_W-1:0]  char_out;
    logic [IDX_W-1:0] member_index;

    modport source (output valid, output event_res, output char_out, output member_index,
                    input ready);
    modport sink   (input valid, input event_res, input char_out, input member_index,
                    output ready);
endinterface

### hw/rtl/stt_class.sv
module stt_class
    import stt_pkg::*;
(
    input  logic [CP_W-1:0]     i_code_point,
    input  logic [KW_POS_W-1:0] i_kw_pos,
    output t_char_class         o_class
);

    logic upper;
    logic lower;
    logic digit;

    assign upper = (i_code_point >= CP_W'(8'h41)) && (i_code_point <= CP_W'(8'h5A));
    assign lower = (i_code_point >= CP_W'(8'h61)) && (i_code_point <= CP_W'(8'h7A));
    assign digit = (i_code_point >= CP_W'(8'h30)) && (i_code_point <= CP_W'(8'h39));

    always_comb begin
        o_class.letter   = upper || lower;
        o_class.word     = upper || lower || digit || (i_code_point == CH_UNDER);
        o_class.blank    = (i_code_point == CH_SPACE) || (i_code_point == CH_TAB);
        o_class.is_s     = (i_code_point == CH_S);
        o_class.rbrace   = (i_code_point == CH_RBRACE);
        o_class.kw_match = (i_code_point == CP_W'(kw_tail(i_kw_pos)));
    end

endmodule

### hw/rtl/stt_parser.sv
module stt_parser
    import stt_pkg::*;
#(
    parameter int TEXT_CAPACITY = TEXT_CAPACITY_DEF,
    parameter int MAX_MEMBERS   = MAX_MEMBERS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_eoi,
    input  t_char_class         i_class,
    output logic [KW_POS_W-1:0] o_kw_pos,
    output t_event              o_event,
    output logic [IDX_W-1:0]    o_member_index
);

    localparam int TL_W = $clog2(TEXT_CAPACITY);
    localparam int MC_W = $clog2(MAX_MEMBERS + 1);
    localparam logic [TL_W-1:0] TL_LAST = TL_W'(TEXT_CAPACITY - 1);
    localparam logic [MC_W-1:0] MC_MAX  = MC_W'(MAX_MEMBERS);

    t_mode               r_mode, n_mode;
    logic [KW_POS_W-1:0] r_kw_pos, n_kw_pos;
    logic [TL_W-1:0]     r_tok_len, n_tok_len;
    logic [MC_W-1:0]     r_mem_cnt, n_mem_cnt;
    t_event              ev;
    logic                tok_full;

    assign tok_full       = (r_tok_len >= TL_LAST);
    assign o_kw_pos       = r_kw_pos;
    assign o_event        = ev;
    assign o_member_index = IDX_W'(r_mem_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_SEEK_S;
            r_kw_pos  <= '0;
            r_tok_len <= '0;
            r_mem_cnt <= '0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_kw_pos  <= n_kw_pos;
            r_tok_len <= n_tok_len;
            r_mem_cnt <= n_mem_cnt;
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_kw_pos  = r_kw_pos;
        n_tok_len = r_tok_len;
        n_mem_cnt = r_mem_cnt;
        ev        = EV_NONE;
        if (r_mode == MODE_HALTED) begin
            ev = EV_NONE;
        end else if (i_eoi) begin
            if (r_mode == MODE_SEEK_S) begin
                ev = EV_FINISHED;
            end else if (r_mode == MODE_KEYWORD) begin
                ev = EV_BAD_KEYWORD;
            end else begin
                ev = EV_UNEXPECTED_END;
            end
            n_mode = MODE_HALTED;
        end else begin
            case (r_mode)
                MODE_SEEK_S: begin
                    if (i_class.is_s) begin
                        n_mode   = MODE_KEYWORD;
                        n_kw_pos = '0;
                    end
                end
                MODE_KEYWORD: begin
                    if (i_class.kw_match) begin
                        n_kw_pos = r_kw_pos + 1'b1;
                        if (r_kw_pos == KW_POS_W'(KW_LEN - 1)) begin
                            n_mode = MODE_BLANKS;
                        end
                    end else begin
                        ev     = EV_BAD_KEYWORD;
                        n_mode = MODE_HALTED;
                    end
                end
                MODE_BLANKS, MODE_NAME: begin
                    if (r_mode == MODE_BLANKS && i_class.blank) begin
                        ev = EV_NONE;
                    end else if (i_class.letter) begin
                        if (tok_full) begin
                            ev     = EV_TOO_LONG;
                            n_mode = MODE_HALTED;
                        end else begin
                            ev        = EV_NAME_CHAR;
                            n_mode    = MODE_NAME;
                            n_tok_len = r_tok_len + 1'b1;
                        end
                    end else begin
                        ev        = EV_NAME_END;
                        n_tok_len = '0;
                        n_mem_cnt = '0;
                        n_mode    = MODE_SEEK_TYPE;
                    end
                end
                MODE_SEEK_TYPE, MODE_TYPE: begin
                    if (i_class.letter) begin
                        if (tok_full) begin
                            ev     = EV_TOO_LONG;
                            n_mode = MODE_HALTED;
                        end else begin
                            ev        = EV_TYPE_CHAR;
                            n_mode    = MODE_TYPE;
                            n_tok_len = r_tok_len + 1'b1;
                        end
                    end else if (r_mode == MODE_TYPE) begin
                        ev        = EV_TYPE_END;
                        n_tok_len = '0;
                        n_mode    = MODE_SEEK_IDENT;
                    end
                end
                MODE_SEEK_IDENT: begin
                    if (i_class.letter) begin
                        if (tok_full) begin
                            ev     = EV_TOO_LONG;
                            n_mode = MODE_HALTED;
                        end else begin
                            ev        = EV_IDENT_CHAR;
                            n_mode    = MODE_IDENT;
                            n_tok_len = r_tok_len + 1'b1;
                        end
                    end else if (i_class.word) begin
                        ev     = EV_BAD_IDENT;
                        n_mode = MODE_HALTED;
                    end
                end
                MODE_IDENT: begin
                    if (i_class.word) begin
                        if (tok_full) begin
                            ev     = EV_TOO_LONG;
                            n_mode = MODE_HALTED;
                        end else begin
                            ev        = EV_IDENT_CHAR;
                            n_tok_len = r_tok_len + 1'b1;
                        end
                    end else begin
                        ev        = EV_IDENT_END;
                        n_tok_len = '0;
                        if (r_mem_cnt < MC_MAX) begin
                            n_mem_cnt = r_mem_cnt + 1'b1;
                        end
                        n_mode = MODE_SEEK_END;
                    end
                end
                MODE_SEEK_END: begin
                    if (i_class.rbrace) begin
                        ev     = EV_STRUCT_END;
                        n_mode = MODE_SEEK_S;
                    end else if (i_class.word) begin
                        if (r_mem_cnt >= MC_MAX) begin
                            ev     = EV_TOO_MANY;
                            n_mode = MODE_HALTED;
                        end else if (i_class.letter) begin
                            if (tok_full) begin
                                ev     = EV_TOO_LONG;
                                n_mode = MODE_HALTED;
                            end else begin
                                ev        = EV_TYPE_CHAR;
                                n_mode    = MODE_TYPE;
                                n_tok_len = r_tok_len + 1'b1;
                            end
                        end else begin
                            ev        = EV_TYPE_END;
                            n_tok_len = '0;
                            n_mode    = MODE_SEEK_IDENT;
                        end
                    end
                end
                default: begin
                    n_mode = MODE_HALTED;
                end
            endcase
        end
    end

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_HALTED |=> r_mode == MODE_HALTED)
        else $error("left halted mode without reset");

    a_tok_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tok_len <= TL_LAST)
        else $error("token length past capacity");

    a_mem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mem_cnt <= MC_MAX)
        else $error("member count past limit");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_mode) && $stable(r_tok_len) && $stable(r_mem_cnt))
        else $error("parser state moved without a word");

endmodule

### hw/rtl/structure_template_tokenizer.sv
// Channel  Dir  Payload                                   Handshake
// i_in     in   code_point[20:0], end_of_input            valid/ready
// o_out    out  event_res[3:0], char_out[20:0],           valid/ready
//               member_index[6:0]
//
// One word in, one word out; a new word is taken every cycle unless the output stalls.
// Each word passes through the input register, then the parse logic into the result register.
// Reset (i_rst_n low, synchronous) empties both registers and returns the parser
// to waiting for the structure keyword.
// A stalled output holds its word; the input register fills, then ready drops.
module structure_template_tokenizer
    import stt_pkg::*;
#(
    parameter int TEXT_CAPACITY = TEXT_CAPACITY_DEF,
    parameter int MAX_MEMBERS   = MAX_MEMBERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stt_in_if.sink      i_in,
    stt_out_if.source   o_out
);

    logic                r_in_valid;
    logic [CP_W-1:0]     r_cp;
    logic                r_eoi;
    logic                r_out_valid;
    logic [EV_W-1:0]     r_event;
    logic [CP_W-1:0]     r_char;
    logic [IDX_W-1:0]    r_idx;
    logic                step;
    logic                take;
    t_char_class         cls;
    logic [KW_POS_W-1:0] kw_pos;
    t_event              ev;
    logic [IDX_W-1:0]    idx;
    logic                is_char_ev;

    assign step = r_in_valid && (!r_out_valid || o_out.ready);
    assign take = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cp  <= i_in.code_point;
            r_eoi <= i_in.end_of_input;
        end
    end

    stt_class u_class (
        .i_code_point (r_cp),
        .i_kw_pos     (kw_pos),
        .o_class      (cls)
    );

    stt_parser #(
        .TEXT_CAPACITY (TEXT_CAPACITY),
        .MAX_MEMBERS   (MAX_MEMBERS)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_eoi          (r_eoi),
        .i_class        (cls),
        .o_kw_pos       (kw_pos),
        .o_event        (ev),
        .o_member_index (idx)
    );

    assign is_char_ev = (ev == EV_NAME_CHAR) || (ev == EV_TYPE_CHAR) || (ev == EV_IDENT_CHAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_event <= EV_W'(ev);
            r_char  <= is_char_ev ? r_cp : '0;
            r_idx   <= idx;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_res    = r_event;
    assign o_out.char_out     = r_char;
    assign o_out.member_index = r_idx;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import stt_pkg::*;

    localparam int TOKEN_MAX = TEXT_CAPACITY_DEF - 1;
    localparam logic [8*KW_LEN-1:0] KW_TAIL = "tructure";

    typedef struct packed {
        t_event           ev;
        logic [CP_W-1:0]  ch;
        logic [IDX_W-1:0] idx;
    } t_token_event;

    typedef enum {
        GAP_PRE_KEYWORD,
        GAP_NON_LETTER,
        GAP_NAME_STOP,
        GAP_NON_WORD,
        GAP_MEMBER
    } t_gap_kind;

    typedef enum {
        HALT_FINISHED,
        HALT_KW_CHAR,
        HALT_KW_EOI,
        HALT_TOO_LONG,
        HALT_BAD_IDENT,
        HALT_TOO_MANY,
        HALT_EARLY_END
    } t_halt_case;

    logic i_clk;
    logic i_rst_n;

    stt_in_if  in_if ();
    stt_out_if out_if ();

    structure_template_tokenizer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_mode       tk_mode    = MODE_SEEK_S;
    int unsigned kw_idx     = 0;
    int unsigned tok_len    = 0;
    int unsigned member_cnt = 0;

    t_token_event expected_events[$];
    int mismatches  = 0;
    int sent_items  = 0;
    int src_idle    = 0;
    int snk_idle    = 0;
    int gap_limit   = 2;
    int phase_items = 130;
    t_halt_case halt_pick;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [CP_W-1:0] tail_char(input int i);
        return CP_W'(KW_TAIL[8*(KW_LEN-1-i) +: 8]);
    endfunction

    function automatic bit is_alpha(input logic [CP_W-1:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_word(input logic [CP_W-1:0] c);
        return is_alpha(c) || (c >= "0" && c <= "9") || c == CH_UNDER;
    endfunction

    function automatic bit is_blank(input logic [CP_W-1:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic t_event grow_token(input t_event ok_ev);
        if (tok_len >= TOKEN_MAX) begin
            tk_mode = MODE_HALTED;
            return EV_TOO_LONG;
        end
        tok_len++;
        return ok_ev;
    endfunction

    function automatic t_token_event tokenize_char(input logic [CP_W-1:0] c, input logic eoi);
        t_token_event r;
        r.ev  = EV_NONE;
        r.ch  = '0;
        r.idx = IDX_W'(member_cnt);
        if (tk_mode == MODE_HALTED) begin
            r.ev = EV_NONE;
        end else if (eoi) begin
            if (tk_mode == MODE_SEEK_S)
                r.ev = EV_FINISHED;
            else if (tk_mode == MODE_KEYWORD)
                r.ev = EV_BAD_KEYWORD;
            else
                r.ev = EV_UNEXPECTED_END;
            tk_mode = MODE_HALTED;
        end else begin
            case (tk_mode)
                MODE_SEEK_S: begin
                    if (c == CH_S) begin
                        tk_mode = MODE_KEYWORD;
                        kw_idx  = 0;
                    end
                end
                MODE_KEYWORD: begin
                    if (c == tail_char(kw_idx)) begin
                        kw_idx++;
                        if (kw_idx == KW_LEN) begin
                            kw_idx  = 0;
                            tk_mode = MODE_BLANKS;
                        end
                    end else begin
                        r.ev    = EV_BAD_KEYWORD;
                        tk_mode = MODE_HALTED;
                    end
                end
                MODE_BLANKS, MODE_NAME: begin
                    if (!(tk_mode == MODE_BLANKS && is_blank(c))) begin
                        if (is_alpha(c)) begin
                            tk_mode = MODE_NAME;
                            r.ev    = grow_token(EV_NAME_CHAR);
                        end else begin
                            r.ev       = EV_NAME_END;
                            tok_len    = 0;
                            member_cnt = 0;
                            tk_mode    = MODE_SEEK_TYPE;
                        end
                    end
                end
                MODE_SEEK_TYPE: begin
                    if (is_alpha(c)) begin
                        tk_mode = MODE_TYPE;
                        r.ev    = grow_token(EV_TYPE_CHAR);
                    end
                end
                MODE_TYPE: begin
                    if (is_alpha(c)) begin
                        r.ev = grow_token(EV_TYPE_CHAR);
                    end else begin
                        r.ev    = EV_TYPE_END;
                        tok_len = 0;
                        tk_mode = MODE_SEEK_IDENT;
                    end
                end
                MODE_SEEK_IDENT: begin
                    if (is_alpha(c)) begin
                        tk_mode = MODE_IDENT;
                        r.ev    = grow_token(EV_IDENT_CHAR);
                    end else if (is_word(c)) begin
                        r.ev    = EV_BAD_IDENT;
                        tk_mode = MODE_HALTED;
                    end
                end
                MODE_IDENT: begin
                    if (is_word(c)) begin
                        r.ev = grow_token(EV_IDENT_CHAR);
                    end else begin
                        r.ev    = EV_IDENT_END;
                        tok_len = 0;
                        if (member_cnt < MAX_MEMBERS_DEF)
                            member_cnt++;
                        tk_mode = MODE_SEEK_END;
                    end
                end
                MODE_SEEK_END: begin
                    if (c == CH_RBRACE) begin
                        r.ev    = EV_STRUCT_END;
                        tk_mode = MODE_SEEK_S;
                    end else if (is_word(c)) begin
                        if (member_cnt >= MAX_MEMBERS_DEF) begin
                            r.ev    = EV_TOO_MANY;
                            tk_mode = MODE_HALTED;
                        end else if (is_alpha(c)) begin
                            tk_mode = MODE_TYPE;
                            r.ev    = grow_token(EV_TYPE_CHAR);
                        end else begin
                            r.ev    = EV_TYPE_END;
                            tok_len = 0;
                            tk_mode = MODE_SEEK_IDENT;
                        end
                    end
                end
                default: tk_mode = MODE_HALTED;
            endcase
        end
        if (r.ev inside {EV_NAME_CHAR, EV_TYPE_CHAR, EV_IDENT_CHAR})
            r.ch = c;
        return r;
    endfunction

    function automatic logic [CP_W-1:0] rand_alpha();
        logic [CP_W-1:0] base;
        base = $urandom_range(1) ? CP_W'("A") : CP_W'("a");
        return base + CP_W'($urandom_range(25));
    endfunction

    function automatic logic [CP_W-1:0] rand_digit_us();
        if ($urandom_range(10) == 10)
            return CH_UNDER;
        return CP_W'("0") + CP_W'($urandom_range(9));
    endfunction

    function automatic logic [CP_W-1:0] rand_word_char();
        if ($urandom_range(2) == 0)
            return rand_digit_us();
        return rand_alpha();
    endfunction

    function automatic logic [CP_W-1:0] rand_cp();
        case ($urandom_range(8))
            0:       return CP_W'($urandom_range(21'h1FFFFF));
            1:       return CP_W'($urandom_range(21'h10FFFF, 128));
            2:       return CP_W'($urandom_range(127));
            3:       return CH_SPACE;
            4:       return CH_TAB;
            5:       return CH_RBRACE;
            6:       return rand_alpha();
            7:       return $urandom_range(1) ? '0 : '1;
            default: return rand_digit_us();
        endcase
    endfunction

    function automatic logic [CP_W-1:0] rand_gap_char(input t_gap_kind k);
        logic [CP_W-1:0] c;
        bit ok;
        do begin
            c = rand_cp();
            case (k)
                GAP_PRE_KEYWORD: ok = (c != CH_S);
                GAP_NON_LETTER:  ok = !is_alpha(c);
                GAP_NAME_STOP:   ok = !is_alpha(c) && !is_blank(c);
                GAP_NON_WORD:    ok = !is_word(c);
                default:         ok = !is_word(c) && c != CH_RBRACE;
            endcase
        end while (!ok);
        return c;
    endfunction

    function automatic int rand_len(input int min_len);
        if ($urandom_range(24) == 0)
            return TOKEN_MAX;
        return $urandom_range(6, min_len);
    endfunction

    task automatic send_word(input logic [CP_W-1:0] cp, input logic eoi);
        while ($urandom_range(99) < src_idle) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.code_point   <= cp;
        in_if.end_of_input <= eoi;
        expected_events.push_back(tokenize_char(cp, eoi));
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        sent_items++;
    endtask

    task automatic send_gap(input t_gap_kind k);
        repeat ($urandom_range(gap_limit))
            send_word(rand_gap_char(k), 1'b0);
    endtask

    task automatic send_letters(input int n);
        repeat (n)
            send_word(rand_alpha(), 1'b0);
    endtask

    task automatic send_ident(input int n);
        send_word(rand_alpha(), 1'b0);
        repeat (n - 1)
            send_word(rand_word_char(), 1'b0);
    endtask

    task automatic send_keyword(input int n_tail);
        send_word(CH_S, 1'b0);
        for (int i = 0; i < n_tail; i++)
            send_word(tail_char(i), 1'b0);
    endtask

    task automatic send_header(input int name_len);
        send_gap(GAP_PRE_KEYWORD);
        send_keyword(KW_LEN);
        repeat ($urandom_range(gap_limit))
            send_word($urandom_range(1) ? CH_SPACE : CH_TAB, 1'b0);
        send_letters(name_len);
        send_word(rand_gap_char(name_len == 0 ? GAP_NAME_STOP : GAP_NON_LETTER), 1'b0);
    endtask

    task automatic send_type(input bit first, input int len);
        if (first) begin
            send_gap(GAP_NON_LETTER);
        end else begin
            send_gap(GAP_MEMBER);
        end
        if (len == 0) begin
            send_word(rand_digit_us(), 1'b0);
        end else begin
            send_letters(len);
            send_word(rand_gap_char(GAP_NON_LETTER), 1'b0);
        end
    endtask

    task automatic send_member(input bit first, input int tlen, input int ilen);
        send_type(first, tlen);
        send_gap(GAP_NON_WORD);
        send_ident(ilen);
        send_word(rand_gap_char(GAP_NON_WORD), 1'b0);
    endtask

    task automatic send_structure(input int n_members);
        send_header(rand_len(0));
        for (int i = 0; i < n_members; i++)
            send_member(i == 0, rand_len(i == 0 ? 1 : 0), rand_len(1));
        send_gap(GAP_MEMBER);
        send_word(CH_RBRACE, 1'b0);
    endtask

    task automatic test_directed_flow();
        send_word(21'h000000, 1'b0);
        send_word(21'h1FFFFF, 1'b0);
        send_word(21'h10FFFF, 1'b0);
        send_keyword(KW_LEN);
        send_word(CH_TAB, 1'b0);
        send_word(CH_SPACE, 1'b0);
        send_word("Z", 1'b0);
        send_word("a", 1'b0);
        send_word("{", 1'b0);
        send_word(CH_UNDER, 1'b0);
        send_word(21'h000080, 1'b0);
        send_word("z", 1'b0);
        send_word("A", 1'b0);
        send_word(CH_SPACE, 1'b0);
        send_word(CH_RBRACE, 1'b0);
        send_word("x", 1'b0);
        send_word("9", 1'b0);
        send_word(CH_UNDER, 1'b0);
        send_word(CH_RBRACE, 1'b0);
        send_word(21'h1FFFFF, 1'b0);
        send_word("0", 1'b0);
        send_word("q", 1'b0);
        send_word(";", 1'b0);
        send_word(CH_RBRACE, 1'b0);
    endtask

    task automatic test_drain_pause();
        in_if.valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_random_structures(input int n);
        int stop;
        stop = sent_items + n;
        while (sent_items < stop)
            send_structure($urandom_range(7) == 0 ? $urandom_range(10, 5) : $urandom_range(3, 1));
    endtask

    task automatic test_halting_case(input t_halt_case pick);
        int              k;
        logic [CP_W-1:0] c;
        case (pick)
            HALT_FINISHED: begin
                send_word(rand_cp(), 1'b1);
            end
            HALT_KW_CHAR: begin
                k = $urandom_range(KW_LEN - 1);
                send_keyword(k);
                do c = rand_cp(); while (c == tail_char(k));
                send_word(c, 1'b0);
            end
            HALT_KW_EOI: begin
                send_keyword($urandom_range(KW_LEN - 1));
                send_word(rand_cp(), 1'b1);
            end
            HALT_TOO_LONG: begin
                case ($urandom_range(2))
                    0: begin
                        send_keyword(KW_LEN);
                        send_letters(TOKEN_MAX + 1);
                    end
                    1: begin
                        send_header(rand_len(0));
                        send_gap(GAP_NON_LETTER);
                        send_letters(TOKEN_MAX + 1);
                    end
                    default: begin
                        send_header(rand_len(0));
                        send_type(1'b1, rand_len(1));
                        send_gap(GAP_NON_WORD);
                        send_ident(TOKEN_MAX + 1);
                    end
                endcase
            end
            HALT_BAD_IDENT: begin
                send_header(rand_len(0));
                send_type(1'b1, rand_len(1));
                if ($urandom_range(1)) begin
                    send_gap(GAP_NON_WORD);
                    send_ident(rand_len(1));
                    send_word(rand_gap_char(GAP_NON_WORD), 1'b0);
                    send_type(1'b0, 0);
                end
                send_gap(GAP_NON_WORD);
                send_word(rand_digit_us(), 1'b0);
            end
            HALT_TOO_MANY: begin
                gap_limit = 0;
                send_header(rand_len(0));
                for (int i = 0; i < MAX_MEMBERS_DEF; i++)
                    send_member(i == 0, i == 0 ? 1 : $urandom_range(1), 1);
                send_word($urandom_range(1) ? rand_alpha() : rand_digit_us(), 1'b0);
                gap_limit = 2;
            end
            default: begin
                case ($urandom_range(2))
                    0: send_keyword(KW_LEN);
                    1: begin
                        send_keyword(KW_LEN);
                        send_letters($urandom_range(3, 1));
                    end
                    default: begin
                        send_header(rand_len(0));
                        k = $urandom_range(2);
                        for (int i = 0; i < k; i++)
                            send_member(i == 0, rand_len(i == 0 ? 1 : 0), rand_len(1));
                        if ($urandom_range(1))
                            send_letters($urandom_range(3, 1));
                    end
                endcase
                send_word(rand_cp(), 1'b1);
            end
        endcase
        repeat (8)
            send_word(rand_cp(), 1'($urandom_range(1)));
    endtask

    function automatic void note_mismatch(input string msg);
        if (mismatches < 10)
            $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endfunction

    always @(posedge i_clk) begin
        t_token_event want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_events.size() == 0) begin
                note_mismatch($sformatf("unexpected word event_res %0d char_out %h idx %0d",
                                        out_if.event_res, out_if.char_out,
                                        out_if.member_index));
            end else begin
                want = expected_events.pop_front();
                if (out_if.event_res !== want.ev || out_if.char_out !== want.ch ||
                    out_if.member_index !== want.idx) begin
                    note_mismatch($sformatf(
                        "event_res exp %0d got %0d, char_out exp %h got %h, idx exp %0d got %0d",
                        want.ev, out_if.event_res, want.ch, out_if.char_out,
                        want.idx, out_if.member_index));
                end
            end
        end
    end

    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.code_point   <= '0;
        in_if.end_of_input <= 1'b0;
        src_idle = 8;
        snk_idle = 70;
        halt_pick = t_halt_case'($urandom_range(HALT_EARLY_END));
        phase_items = (halt_pick == HALT_TOO_MANY) ? 10 : 130;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_flow();
        test_drain_pause();
        test_random_structures(phase_items);
        src_idle = 70;
        snk_idle = 8;
        test_random_structures(phase_items);
        src_idle = 0;
        snk_idle = 0;
        test_random_structures(phase_items);
        test_halting_case(halt_pick);

        test_drain_pause();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
